@@ rtl/msd_pkg.sv @@
// Shared types, constants and helpers of the moisture detector.
package msd_pkg;

  localparam int BUCKETS    = 10;
  localparam int CHANNELS   = 2;
  localparam int COUNT_BITS = 16;

  localparam int BK_W   = $clog2(BUCKETS);
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TIME_W = 40;
  localparam int CNT_W  = 8;
  localparam int CFG_AW = 5;
  localparam int OUT_DW = 32;

  localparam int STORM_SPAN_MS     = 2000;
  localparam int BUCKET_MS         = STORM_SPAN_MS / BUCKETS;
  localparam int RESTORE_DELAY_MS  = 120000;
  localparam int REPORT_SPACING_MS = (24 * 60 * 60) * 1000;

  typedef enum logic [1:0] {
    CMD_CC      = 2'd0,
    CMD_VBUS    = 2'd1,
    CMD_UNBLANK = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    NTF_NONE  = 2'd0,
    NTF_MOIST = 2'd1,
    NTF_DRY   = 2'd2
  } notify_t;

  typedef enum logic [2:0] {
    REG_INTERVAL  = 3'd0,
    REG_THRESHOLD = 3'd1,
    REG_EVENT_EN  = 3'd2,
    REG_FLAG_EN   = 3'd3,
    REG_REPORT_EN = 3'd4,
    REG_UNBLANK_EN = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_EVAL,
    ST_MERGE,
    ST_STATUS,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic [15:0] interval_ms;
    logic [7:0]  threshold;
    logic        event_en;
    logic        flag_en;
    logic        report_en;
    logic        unblank_en;
  } cfg_t;

  typedef struct packed {
    logic            capture;
    logic            prep;
    logic            eval;
    logic            merge;
    logic            load_status;
    logic            load_report;
    logic [BK_W-1:0] bkt;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;
    logic do_report;
    logic out_free;
  } dp_stat_t;

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                    input logic [COUNT_BITS-1:0] b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
  endfunction

endpackage

@@ rtl/msd_cfg.sv @@
// Configuration register file on the APB-style port.
module msd_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [msd_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready,
  output msd_pkg::cfg_t             cfg
);
  import msd_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = reg_idx_t'(cfg_paddr[CFG_AW-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_INTERVAL:   cfg_nxt.interval_ms = cfg_pwdata[15:0];
        REG_THRESHOLD:  cfg_nxt.threshold   = cfg_pwdata[7:0];
        REG_EVENT_EN:   cfg_nxt.event_en    = cfg_pwdata[0];
        REG_FLAG_EN:    cfg_nxt.flag_en     = cfg_pwdata[0];
        REG_REPORT_EN:  cfg_nxt.report_en   = cfg_pwdata[0];
        REG_UNBLANK_EN: cfg_nxt.unblank_en  = cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_INTERVAL:   cfg_prdata = {16'd0, cfg_r.interval_ms};
      REG_THRESHOLD:  cfg_prdata = {24'd0, cfg_r.threshold};
      REG_EVENT_EN:   cfg_prdata = {31'd0, cfg_r.event_en};
      REG_FLAG_EN:    cfg_prdata = {31'd0, cfg_r.flag_en};
      REG_REPORT_EN:  cfg_prdata = {31'd0, cfg_r.report_en};
      REG_UNBLANK_EN: cfg_prdata = {31'd0, cfg_r.unblank_en};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.interval_ms <= 16'd2000;
      cfg_r.threshold   <= 8'd50;
      cfg_r.event_en    <= 1'b0;
      cfg_r.flag_en     <= 1'b0;
      cfg_r.report_en   <= 1'b1;
      cfg_r.unblank_en  <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ rtl/msd_ctrl.sv @@
// Controller state machine sequencing evaluation, bucket merge and report output.
module msd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output msd_pkg::ctrl_cmd_t    cmd,
  input  msd_pkg::dp_stat_t     stat
);
  import msd_pkg::*;

  state_t          state_r, state_nxt;
  logic [BK_W-1:0] bkt_r, bkt_nxt;
  logic            bkt_last;

  assign bkt_last = (bkt_r == BK_W'(BUCKETS - 1));

  always_comb begin
    state_nxt = state_r;
    bkt_nxt   = bkt_r;
    in_tready = 1'b0;
    cmd       = '0;
    cmd.bkt   = bkt_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        bkt_nxt   = '0;
        state_nxt = ST_MERGE;
      end
      ST_MERGE: begin
        if (!stat.hit) begin
          state_nxt = ST_STATUS;
        end else begin
          cmd.merge = 1'b1;
          if (bkt_last) begin
            state_nxt = ST_STATUS;
          end else begin
            bkt_nxt = bkt_r + BK_W'(1);
          end
        end
      end
      ST_STATUS: begin
        if (stat.out_free) begin
          cmd.load_status = 1'b1;
          bkt_nxt         = '0;
          state_nxt       = stat.do_report ? ST_REPORT : ST_IDLE;
        end
      end
      ST_REPORT: begin
        if (stat.out_free) begin
          cmd.load_report = 1'b1;
          if (bkt_last) begin
            state_nxt = ST_IDLE;
          end else begin
            bkt_nxt = bkt_r + BK_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      bkt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      bkt_r   <= bkt_nxt;
    end
  end

endmodule

@@ rtl/msd_dp.sv @@
// Datapath: channel state, gap and report histograms, flags and output register.
module msd_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  msd_pkg::cfg_t               cfg,
  input  msd_pkg::ctrl_cmd_t          cmd,
  output msd_pkg::dp_stat_t           stat,
  input  logic [msd_pkg::TIME_W-1:0]  in_tdata,
  input  logic [1:0]                  in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [msd_pkg::OUT_DW-1:0]  out_tdata,
  output logic                        out_tuser,
  output logic                        out_tlast
);
  import msd_pkg::*;

  cmd_t                  cmd_r, cmd_nxt;
  logic [TIME_W-1:0]     now_r, now_nxt;

  logic                  expired_r, expired_nxt;
  logic                  long_r, long_nxt;
  logic [BK_W-1:0]       idx_r, idx_nxt;
  logic                  due_r, due_nxt;
  logic [TIME_W-1:0]     dl_r, dl_nxt;

  logic                  seen_r [CHANNELS];
  logic                  seen_nxt [CHANNELS];
  logic [TIME_W-1:0]     let_r [CHANNELS];
  logic [TIME_W-1:0]     let_nxt [CHANNELS];
  logic [CNT_W-1:0]      cnt_r [CHANNELS];
  logic [CNT_W-1:0]      cnt_nxt [CHANNELS];
  logic                  pend_r [CHANNELS];
  logic                  pend_nxt [CHANNELS];
  logic [TIME_W-1:0]     lrt_r [CHANNELS];
  logic [TIME_W-1:0]     lrt_nxt [CHANNELS];
  logic [COUNT_BITS-1:0] gap_r [CHANNELS][BUCKETS];
  logic [COUNT_BITS-1:0] gap_nxt [CHANNELS][BUCKETS];
  logic [COUNT_BITS-1:0] rep_r [CHANNELS][BUCKETS];
  logic [COUNT_BITS-1:0] rep_nxt [CHANNELS][BUCKETS];

  logic                  status_r, status_nxt;
  logic                  happened_r, happened_nxt;
  logic                  mode_r, mode_nxt;
  logic                  armed_r, armed_nxt;
  logic [TIME_W-1:0]     deadline_r, deadline_nxt;

  logic                  hit_r, hit_nxt;
  logic                  do_report_r, do_report_nxt;
  notify_t               notify_r, notify_nxt;

  logic                  ov_r, ov_nxt;
  logic [OUT_DW-1:0]     od_r, od_nxt;
  logic                  ou_r, ou_nxt;
  logic                  ol_r, ol_nxt;

  logic [CH_W-1:0]       ch;
  logic                  is_evt;
  logic [TIME_W:0]       diff;
  logic [TIME_W:0]       due_sum;
  logic [TIME_W:0]       dl_sum;
  logic [BK_W-1:0]       idx_w;
  logic [CNT_W-1:0]      cnt_v;
  logic                  pend_v;
  logic                  armed_v;
  logic                  status_v;
  logic                  happened_v;
  logic                  mode_v;
  logic                  hit_v;
  logic                  rep_v;
  notify_t               notify_v;

  assign ch     = CH_W'(cmd_r[0]);
  assign is_evt = ((cmd_r == CMD_CC) || (cmd_r == CMD_VBUS)) && (int'(cmd_r) < CHANNELS);

  assign diff    = {1'b0, now_r} - {1'b0, let_r[ch]};
  assign due_sum = {1'b0, lrt_r[ch]} + (TIME_W + 1)'(REPORT_SPACING_MS);
  assign dl_sum  = {1'b0, now_r} + (TIME_W + 1)'(RESTORE_DELAY_MS);

  always_comb begin
    idx_w = '0;
    for (int k = 1; k < BUCKETS; k++) begin
      if (diff[15:0] >= 16'(k * BUCKET_MS)) begin
        idx_w = idx_w + BK_W'(1);
      end
    end
  end

  assign stat.hit       = hit_r;
  assign stat.do_report = do_report_r;
  assign stat.out_free  = !ov_r || out_tready;

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;
  assign out_tlast  = ol_r;

  always_comb begin
    cmd_nxt       = cmd_r;
    now_nxt       = now_r;
    expired_nxt   = expired_r;
    long_nxt      = long_r;
    idx_nxt       = idx_r;
    due_nxt       = due_r;
    dl_nxt        = dl_r;
    seen_nxt      = seen_r;
    let_nxt       = let_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    lrt_nxt       = lrt_r;
    gap_nxt       = gap_r;
    rep_nxt       = rep_r;
    status_nxt    = status_r;
    happened_nxt  = happened_r;
    mode_nxt      = mode_r;
    armed_nxt     = armed_r;
    deadline_nxt  = deadline_r;
    hit_nxt       = hit_r;
    do_report_nxt = do_report_r;
    notify_nxt    = notify_r;
    ov_nxt        = ov_r;
    od_nxt        = od_r;
    ou_nxt        = ou_r;
    ol_nxt        = ol_r;

    cnt_v      = cnt_r[ch];
    pend_v     = pend_r[ch];
    armed_v    = armed_r;
    status_v   = status_r;
    happened_v = happened_r;
    mode_v     = mode_r;
    hit_v      = 1'b0;
    rep_v      = 1'b0;
    notify_v   = NTF_NONE;

    if (cmd.capture) begin
      cmd_nxt = cmd_t'(in_tuser);
      now_nxt = in_tdata;
    end

    if (cmd.prep) begin
      expired_nxt = armed_r && (now_r >= deadline_r);
      long_nxt    = diff[TIME_W] || (diff[TIME_W-1:16] != '0) ||
                    (diff[15:0] > cfg.interval_ms);
      idx_nxt     = idx_w;
      due_nxt     = due_sum < {1'b0, now_r};
      dl_nxt      = dl_sum[TIME_W] ? {TIME_W{1'b1}} : dl_sum[TIME_W-1:0];
    end

    if (cmd.eval) begin
      if (expired_r) begin
        armed_v = 1'b0;
        if (!happened_r) begin
          status_v = 1'b0;
        end
      end
      if (is_evt) begin
        let_nxt[ch] = now_r;
        if (!seen_r[ch]) begin
          seen_nxt[ch] = 1'b1;
        end else if (long_r) begin
          cnt_v = '0;
          for (int b = 0; b < BUCKETS; b++) begin
            gap_nxt[ch][b] = '0;
          end
        end else begin
          if (cnt_v != {CNT_W{1'b1}}) begin
            cnt_v = cnt_v + CNT_W'(1);
          end
          gap_nxt[ch][idx_r] = sat_add(gap_r[ch][idx_r], COUNT_BITS'(1));
        end
        if (cnt_v >= cfg.threshold) begin
          hit_v = 1'b1;
          if (cfg.flag_en) begin
            happened_v = 1'b1;
            status_v   = 1'b1;
          end
          cnt_v  = '0;
          pend_v = 1'b1;
          if (cfg.event_en) begin
            notify_v = NTF_MOIST;
          end
          mode_v = 1'b1;
        end
        if (cfg.report_en && pend_v) begin
          pend_v = 1'b0;
          rep_v  = due_r;
        end
        cnt_nxt[ch]  = cnt_v;
        pend_nxt[ch] = pend_v;
      end else if ((cmd_r == CMD_UNBLANK) && cfg.unblank_en) begin
        mode_v   = 1'b0;
        notify_v = NTF_DRY;
        if (cfg.flag_en) begin
          happened_v = 1'b0;
          if (!armed_v) begin
            armed_v      = 1'b1;
            deadline_nxt = dl_r;
          end
        end
      end
      armed_nxt     = armed_v;
      status_nxt    = status_v;
      happened_nxt  = happened_v;
      mode_nxt      = mode_v;
      hit_nxt       = hit_v;
      do_report_nxt = rep_v;
      notify_nxt    = notify_v;
    end

    if (cmd.merge) begin
      rep_nxt[ch][cmd.bkt] = sat_add(rep_r[ch][cmd.bkt], gap_r[ch][cmd.bkt]);
      gap_nxt[ch][cmd.bkt] = '0;
    end

    if (cmd.load_status) begin
      ov_nxt = 1'b1;
      od_nxt = {6'd0, 16'd0, 4'd0, 1'b0, hit_r, notify_r, mode_r, status_r};
      ou_nxt = 1'b0;
      ol_nxt = !do_report_r;
    end else if (cmd.load_report) begin
      ov_nxt = 1'b1;
      od_nxt = {6'd0, 16'(rep_r[ch][cmd.bkt]), 4'(cmd.bkt), 1'(ch), 1'b0,
                NTF_NONE, mode_r, status_r};
      ou_nxt = 1'b1;
      ol_nxt = (cmd.bkt == BK_W'(BUCKETS - 1));
      rep_nxt[ch][cmd.bkt] = '0;
      if (cmd.bkt == BK_W'(BUCKETS - 1)) begin
        lrt_nxt[ch] = now_r;
      end
    end else if (out_tready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    now_r       <= now_nxt;
    expired_r   <= expired_nxt;
    long_r      <= long_nxt;
    idx_r       <= idx_nxt;
    due_r       <= due_nxt;
    dl_r        <= dl_nxt;
    hit_r       <= hit_nxt;
    do_report_r <= do_report_nxt;
    notify_r    <= notify_nxt;
    od_r        <= od_nxt;
    ou_r        <= ou_nxt;
    ol_r        <= ol_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        seen_r[c] <= 1'b0;
        let_r[c]  <= '0;
        cnt_r[c]  <= '0;
        pend_r[c] <= 1'b0;
        lrt_r[c]  <= '0;
        for (int b = 0; b < BUCKETS; b++) begin
          gap_r[c][b] <= '0;
          rep_r[c][b] <= '0;
        end
      end
      status_r   <= 1'b0;
      happened_r <= 1'b0;
      mode_r     <= 1'b0;
      armed_r    <= 1'b0;
      deadline_r <= '0;
      ov_r       <= 1'b0;
    end else begin
      seen_r     <= seen_nxt;
      let_r      <= let_nxt;
      cnt_r      <= cnt_nxt;
      pend_r     <= pend_nxt;
      lrt_r      <= lrt_nxt;
      gap_r      <= gap_nxt;
      rep_r      <= rep_nxt;
      status_r   <= status_nxt;
      happened_r <= happened_nxt;
      mode_r     <= mode_nxt;
      armed_r    <= armed_nxt;
      deadline_r <= deadline_nxt;
      ov_r       <= ov_nxt;
    end
  end

endmodule

@@ rtl/cc_event_storm_moisture_detector.sv @@
// Top level of the CC/VBUS event storm moisture detector.
// Usage:
//   Input stream: one item per event; in_tuser carries the command (cc change,
//   vbus change, screen unblank, time tick), in_tdata the 40-bit time in ms.
//   Output stream: every item gives one status item; a due histogram report
//   adds one item per bucket, in bucket order. out_tlast marks the final item
//   of each input, out_tuser flags report items.
//   Configuration: APB-style port, registers at byte address 4*index.
// Sequence: an item passes capture, prepare, evaluate, storm check and status;
//   on a storm the check walks the gap buckets, merging each into the report
//   histogram, and a due report adds a walk that emits one item per bucket.
// Reset: rst_n clears all channel state, histograms, flags and the output
//   valid flag; configuration returns to its defaults.
// Stall: a single output register holds the pending item while out_tready is
//   low; the block then waits, and takes the next input once the final item of
//   the current one is loaded.
module cc_event_storm_moisture_detector (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [39:0] now_ms
  input  logic [msd_pkg::TIME_W-1:0]  in_tdata,
  // [1:0] cmd
  input  logic [1:0]                  in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [0] moist_flag, [1] cc_mode, [3:2] notify_event, [4] storm_hit,
  // [5] report_channel, [9:6] bucket_index, [25:10] bucket_count, [31:26] zero
  output logic [msd_pkg::OUT_DW-1:0]  out_tdata,
  // [0] is_report
  output logic                        out_tuser,
  output logic                        out_tlast,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [msd_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import msd_pkg::*;

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  msd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  msd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  msd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

@@ rtl/msd_checker.sv @@
// Port-level checker for the moisture detector, bound to the top level.
module msd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [msd_pkg::OUT_DW-1:0]  out_tdata,
  input logic                        out_tuser,
  input logic                        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output item changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again before the item was processed");

  a_ready_only_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid || out_tlast)
    else $error("input ready while a non-final item is pending");

  a_status_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[25:5] == 21'd0)
    else $error("status item carries report fields");

  a_report_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[4:2] == 3'd0)
    else $error("report item carries notify or storm flags");

endmodule

bind cc_event_storm_moisture_detector msd_checker u_msd_checker (.*);
